@@ design/scalc_pkg.sv @@
package scalc_pkg;

    // Sizes of the operand stack and the variable store.
    localparam int STACK_DEPTH   = 16;
    localparam int NUM_VARIABLES = 16;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);

    // Fixed field widths of the instruction and result requests.
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int VIDX_W = 4;
    localparam int RID_W  = 8;
    localparam int DEPTH_W = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [1:0]        cell_op_t;

    // Instruction codes.
    localparam cmd_t CMD_PUSH  = 3'd0;
    localparam cmd_t CMD_ADD   = 3'd1;
    localparam cmd_t CMD_SUB   = 3'd2;
    localparam cmd_t CMD_MUL   = 3'd3;
    localparam cmd_t CMD_WRITE = 3'd4;
    localparam cmd_t CMD_READ  = 3'd5;
    localparam cmd_t CMD_JUMP  = 3'd6;
    localparam cmd_t CMD_JUMPZ = 3'd7;

    // Stack cell operations: keep, take from the cell above, take from below.
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_PREV = 2'd1;
    localparam cell_op_t CELL_NEXT = 2'd2;

    // Write port of the variable store.
    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] index;
        word_t             data;
    } var_wr_t;

endpackage

@@ design/scalc_cell.sv @@
module scalc_cell (
    input  logic             clk,
    input  scalc_pkg::cell_op_t op,
    input  scalc_pkg::word_t prev_value,
    input  scalc_pkg::word_t next_value,
    output scalc_pkg::word_t value
);
    import scalc_pkg::*;

    word_t value_reg;
    word_t value_next;

    // A push moves entries away from the top, a pop moves them towards it.
    always_comb
    begin
        case (op)
            CELL_PREV: value_next = prev_value;
            CELL_NEXT: value_next = next_value;
            default:   value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ design/scalc_var_store.sv @@
module scalc_var_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scalc_pkg::var_wr_t            wr,
    input  logic [scalc_pkg::VIDX_W-1:0]  rd_index,
    output scalc_pkg::word_t              rd_data
);
    import scalc_pkg::*;

    word_t var_reg [NUM_VARIABLES];

    // Each variable is written when its slot is addressed; reset clears all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VARIABLES; i++)
            begin
                var_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            for (int i = 0; i < NUM_VARIABLES; i++)
            begin
                if (32'(wr.index) == i)
                begin
                    var_reg[i] <= wr.data;
                end
            end
        end
    end

    // A slot beyond the store reads as zero.
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < NUM_VARIABLES; i++)
        begin
            if (32'(rd_index) == i)
            begin
                rd_data = var_reg[i];
            end
        end
    end

endmodule

@@ design/stack_calculator_core.sv @@
// Channel  Direction  Handshake               Payload
// in       request    in_valid / in_ready     command, push_value, var_index, routine_id
// out      result     out_valid / out_ready   top_value, stack_depth, jump_taken,
//                                             jump_routine, overflow
//
// One instruction is executed per cycle while the output is not stalled; its result
// appears in the output register in the cycle after the request is accepted, written
// together with the update of the stack cell row and the variable store.
// Reset clears the stack count, the variable store and the output valid flag.
// A new request is taken while the output register is empty or being emptied,
// so a stalled output holds the input back after one buffered result.
module stack_calculator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] push_value,
    input  logic [3:0]         var_index,
    input  logic [7:0]         routine_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] top_value,
    output logic [4:0]         stack_depth,
    output logic               jump_taken,
    output logic [7:0]         jump_routine,
    output logic               overflow
);
    import scalc_pkg::*;

    logic             count_reg_clear;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    word_t            top_value_reg;
    word_t            top_next;
    logic [4:0]       stack_depth_reg;
    logic             jump_taken_reg;
    logic             jump_next;
    logic [7:0]       jump_routine_reg;
    logic             overflow_reg;
    logic             ovf_next;

    logic             accept;
    cell_op_t         head_op;
    cell_op_t         body_op;
    word_t            head_in;
    word_t            cell_value [STACK_DEPTH];
    word_t            top_word;
    word_t            second_word;
    word_t            var_rd;
    var_wr_t          var_wr;
    var_wr_t          var_wr_gated;
    logic             full;
    logic             empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign top_word    = cell_value[0];
    assign second_word = cell_value[1];
    assign full        = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty       = (count_reg == '0);
    assign count_reg_clear = 1'b0;

    // Decode the instruction into cell moves, the new count and the result.
    always_comb
    begin
        head_op    = CELL_HOLD;
        body_op    = CELL_HOLD;
        head_in    = word_t'(push_value);
        count_next = count_reg;
        ovf_next   = 1'b0;
        jump_next  = 1'b0;
        var_wr     = '0;
        top_next   = empty ? '0 : top_word;
        case (command)
            CMD_PUSH, CMD_READ:
            begin
                head_in = (command == CMD_READ) ? var_rd : word_t'(push_value);
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    head_op    = CELL_PREV;
                    body_op    = CELL_PREV;
                    count_next = count_reg + CNT_W'(1);
                    top_next   = head_in;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL:
            begin
                if (count_reg > CNT_W'(1))
                begin
                    case (command)
                        CMD_ADD: head_in = top_word + second_word;
                        CMD_SUB: head_in = top_word - second_word;
                        default: head_in = top_word * second_word;
                    endcase
                    head_op    = CELL_PREV;
                    body_op    = CELL_NEXT;
                    count_next = count_reg - CNT_W'(1);
                    top_next   = head_in;
                end
                else if (empty)
                begin
                    head_in    = '0;
                    head_op    = CELL_PREV;
                    body_op    = CELL_PREV;
                    count_next = CNT_W'(1);
                    top_next   = '0;
                end
            end
            CMD_WRITE:
            begin
                var_wr.en    = 1'b1;
                var_wr.index = var_index;
                var_wr.data  = empty ? '0 : top_word;
                if (!empty)
                begin
                    head_op    = CELL_NEXT;
                    body_op    = CELL_NEXT;
                    count_next = count_reg - CNT_W'(1);
                    top_next   = (count_reg > CNT_W'(1)) ? second_word : '0;
                end
            end
            CMD_JUMP:
            begin
                jump_next = 1'b1;
            end
            default:
            begin
                if (empty)
                begin
                    jump_next = 1'b1;
                end
                else
                begin
                    jump_next  = (top_word == '0);
                    head_op    = CELL_NEXT;
                    body_op    = CELL_NEXT;
                    count_next = count_reg - CNT_W'(1);
                    top_next   = (count_reg > CNT_W'(1)) ? second_word : '0;
                end
            end
        endcase
    end

    // Row of stack cells, top of stack in the first cell.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        word_t    prev_value;
        word_t    next_value;
        cell_op_t op;

        if (i == 0)
        begin : g_head
            assign prev_value = head_in;
            assign op         = accept ? head_op : CELL_HOLD;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign op         = accept ? body_op : CELL_HOLD;
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign next_value = '0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
        end

        scalc_cell u_cell (
            .clk        (clk),
            .op         (op),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[i])
        );
    end

    // Variable store, written only when the request is accepted.
    always_comb
    begin
        var_wr_gated    = var_wr;
        var_wr_gated.en = var_wr.en && accept;
    end

    scalc_var_store u_vars (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (var_wr_gated),
        .rd_index (var_index),
        .rd_data  (var_rd)
    );

    // Stack count and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (count_reg_clear)
            begin
                count_reg <= '0;
            end
            else if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_value_reg    <= top_next;
            stack_depth_reg  <= count_next[4:0] & {5{1'b1}};
            jump_taken_reg   <= jump_next;
            jump_routine_reg <= jump_next ? routine_id : 8'd0;
            overflow_reg     <= ovf_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign top_value    = top_value_reg;
    assign stack_depth  = stack_depth_reg;
    assign jump_taken   = jump_taken_reg;
    assign jump_routine = jump_routine_reg;
    assign overflow     = overflow_reg;

endmodule
